// File: hdl/isit_pkg.sv
// shared types and constants for the index set interning table
package isit_pkg;

    localparam int MAX_VARS    = 32;
    localparam int STORE_WORDS = 4096;
    localparam int MAX_SETS    = 256;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int SID_W       = $clog2(MAX_SETS);
    localparam int PIDX_W      = $clog2(MAX_VARS);
    localparam int CNT_W       = $clog2(MAX_VARS + 1);
    localparam int UNI_W       = $clog2(2 * MAX_VARS + 1);

    localparam logic [1:0] REQ_INTERN = 2'd0;
    localparam logic [1:0] REQ_MERGE  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BADID = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] element_index;
        logic       last_element;
        logic       empty_set;
        logic [7:0] first_id;
        logic [7:0] second_id;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] set_id;
        logic [4:0] element_out;
        logic [5:0] set_size;
        logic       last_out;
        logic [1:0] status;
    } out_beat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_LEN,
        S_SCAN_LEN_W,
        S_SCAN_CMP,
        S_SCAN_CMP_W,
        S_APPEND,
        S_RES,
        S_MG_LEN,
        S_MG_LEN_W,
        S_MG_ELEM,
        S_MG_ELEM_W,
        S_MG_STEP,
        S_RD_LEN,
        S_RD_LEN_W,
        S_RD_ELEM,
        S_RD_ELEM_W,
        S_RD_OUT
    } state_t;

endpackage

// File: hdl/isit_store.sv
// element store and location map, registered reads
module isit_store
    import isit_pkg::*;
(
    input  logic              aclk,
    input  logic              st_we,
    input  logic [ADDR_W-1:0] st_waddr,
    input  logic [5:0]        st_wdata,
    input  logic [ADDR_W-1:0] st_raddr,
    output logic [5:0]        st_rdata,
    input  logic              lm_we,
    input  logic [SID_W-1:0]  lm_waddr,
    input  logic [ADDR_W-1:0] lm_wdata,
    input  logic [SID_W-1:0]  lm_raddr,
    output logic [ADDR_W-1:0] lm_rdata
);

    logic [5:0]        store_mem [STORE_WORDS];
    logic [ADDR_W-1:0] loc_mem   [MAX_SETS];

    // element store port
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        st_rdata <= store_mem[st_raddr];
    end

    // location map port
    always_ff @(posedge aclk) begin
        if (lm_we) begin
            loc_mem[lm_waddr] <= lm_wdata;
        end
        lm_rdata <= loc_mem[lm_raddr];
    end

endmodule

// File: hdl/index_set_interning_table.sv
// Index set interning table: one request at a time, the next taken after its last beat leaves.
// Intern: element beats are buffered; the last one starts a range check of each element, then a scan
//   of the stored sets (ids 0 and 1 without store reads) comparing elements on equal counts,
//   then, if no set matched, an append of the count word and elements, and a result step.
// Merge: fetch both counts, then build the union element by element, then the intern steps. Read:
//   fetch the count, then each element beat, held by output stalls. Reset (aresetn low,
//   synchronous) clears counters, var_count and control state; the set count resets to 2.
module index_set_interning_table
    import isit_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [5:0] cfg_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    state_t state_reg, state_next;

    logic [5:0]        var_count_reg;
    logic [ADDR_W:0]   used_reg, used_next;
    logic [SID_W:0]    nsets_reg, nsets_next;
    logic [4:0]        pend_mem [MAX_VARS];
    logic [CNT_W-1:0]  pcnt_reg, pcnt_next;
    logic              pover_reg, pover_next;

    // working registers
    logic [UNI_W-1:0]  n_reg, n_next;
    logic [SID_W:0]    sid_reg, sid_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [SID_W-1:0]  id1_reg, id1_next, id2_reg, id2_next;
    logic [ADDR_W-1:0] loc1_reg, loc1_next, loc2_reg, loc2_next;
    logic [CNT_W-1:0]  l1_reg, l1_next, l2_reg, l2_next;
    logic [CNT_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic [5:0]        a_reg, a_next;
    logic              rng_reg, rng_next;
    logic              mg_reg, mg_next;
    logic              side_reg, side_next;
    logic              out_v_reg, out_v_next;
    out_beat_t         out_reg, out_next;

    // union buffer: element pick for intern compare comes from pend or uni
    // a union longer than MAX_VARS fails the range check, so only its count matters
    logic [4:0]        uni_mem [MAX_VARS];
    logic              pend_we, uni_we;
    logic [PIDX_W-1:0] pend_waddr;
    logic [4:0]        pend_wdata, uni_wdata;
    logic [PIDX_W-1:0] uni_waddr;
    logic [4:0]        cur_elem;

    logic              st_we, lm_we;
    logic [ADDR_W-1:0] st_waddr, st_raddr, lm_wdata;
    logic [5:0]        st_wdata, st_rdata;
    logic [SID_W-1:0]  lm_waddr, lm_raddr;
    logic [ADDR_W-1:0] lm_rdata;
    logic [5:0]        eff_vars;
    logic              busy;

    isit_store u_store (
        .aclk     (aclk),
        .st_we    (st_we),
        .st_waddr (st_waddr),
        .st_wdata (st_wdata),
        .st_raddr (st_raddr),
        .st_rdata (st_rdata),
        .lm_we    (lm_we),
        .lm_waddr (lm_waddr),
        .lm_wdata (lm_wdata),
        .lm_raddr (lm_raddr),
        .lm_rdata (lm_rdata)
    );

    assign eff_vars  = (var_count_reg > 6'(MAX_VARS)) ? 6'(MAX_VARS) : var_count_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_v_reg;
    assign m_data    = out_reg;
    assign busy      = (state_reg != S_IDLE);
    assign s_ready   = !busy && !out_v_reg;

    // element of the set under test at position pos
    always_comb begin
        if (mg_reg) begin
            cur_elem = uni_mem[pos_reg[PIDX_W-1:0]];
        end else begin
            cur_elem = pend_mem[pos_reg[PIDX_W-1:0]];
        end
    end

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            var_count_reg <= '0;
        end else if (cfg_valid) begin
            var_count_reg <= cfg_data;
        end
    end

    // small buffers
    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        if (uni_we) begin
            uni_mem[uni_waddr] <= uni_wdata;
        end
    end

    // state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            nsets_reg <= (SID_W+1)'(2);
            pcnt_reg  <= '0;
            pover_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            nsets_reg <= nsets_next;
            pcnt_reg  <= pcnt_next;
            pover_reg <= pover_next;
            out_v_reg <= out_v_next;
        end
        n_reg       <= n_next;
        sid_reg     <= sid_next;
        pos_reg     <= pos_next;
        base_reg    <= base_next;
        id1_reg     <= id1_next;
        id2_reg     <= id2_next;
        loc1_reg    <= loc1_next;
        loc2_reg    <= loc2_next;
        l1_reg      <= l1_next;
        l2_reg      <= l2_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        a_reg       <= a_next;
        rng_reg     <= rng_next;
        mg_reg      <= mg_next;
        side_reg    <= side_next;
        out_reg     <= out_next;
    end

    // next state and datapath
    always_comb begin
        logic [CNT_W-1:0] len;
        logic [5:0]       b;
        logic             fits;
        state_next   = state_reg;
        used_next    = used_reg;
        nsets_next   = nsets_reg;
        pcnt_next    = pcnt_reg;
        pover_next   = pover_reg;
        out_v_next   = out_v_reg;
        n_next       = n_reg;
        sid_next     = sid_reg;
        pos_next     = pos_reg;
        base_next    = base_reg;
        id1_next     = id1_reg;
        id2_next     = id2_reg;
        loc1_next    = loc1_reg;
        loc2_next    = loc2_reg;
        l1_next      = l1_reg;
        l2_next      = l2_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        a_next       = a_reg;
        rng_next     = rng_reg;
        mg_next      = mg_reg;
        side_next    = side_reg;
        out_next     = out_reg;
        pend_we      = 1'b0;
        pend_waddr   = pcnt_reg[PIDX_W-1:0];
        pend_wdata   = s_data.element_index;
        uni_we       = 1'b0;
        uni_waddr    = n_reg[PIDX_W-1:0];
        uni_wdata    = a_reg[4:0];
        st_we        = 1'b0;
        st_waddr     = used_reg[ADDR_W-1:0];
        st_wdata     = '0;
        st_raddr     = '0;
        lm_we        = 1'b0;
        lm_waddr     = nsets_reg[SID_W-1:0];
        lm_wdata     = used_reg[ADDR_W-1:0];
        lm_raddr     = '0;
        len          = '0;
        b            = '0;
        fits         = 1'b0;

        if (out_v_reg && m_ready) begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    id1_next = s_data.first_id[SID_W-1:0];
                    id2_next = s_data.second_id[SID_W-1:0];
                    case (s_data.req_type)
                        REQ_INTERN: begin
                            if (s_data.empty_set) begin
                                pcnt_next  = '0;
                                pover_next = 1'b0;
                                out_next   = '{8'd0, 5'd0, 6'd0, 1'b1, ST_OK};
                                out_v_next = 1'b1;
                            end else begin
                                if (pcnt_reg < CNT_W'(MAX_VARS)) begin
                                    pend_we   = 1'b1;
                                    pcnt_next = pcnt_reg + 1'b1;
                                end else begin
                                    pover_next = 1'b1;
                                end
                                if (s_data.last_element) begin
                                    n_next     = UNI_W'(pcnt_next);
                                    mg_next    = 1'b0;
                                    rng_next   = 1'b0;
                                    pos_next   = '0;
                                    state_next = S_CHECK;
                                end
                            end
                        end
                        REQ_MERGE: begin
                            if ({1'b0, s_data.first_id} >= 9'(nsets_reg) ||
                                {1'b0, s_data.second_id} >= 9'(nsets_reg)) begin
                                out_next   = '{8'd0, 5'd0, 6'd0, 1'b1, ST_BADID};
                                out_v_next = 1'b1;
                            end else begin
                                mg_next    = 1'b1;
                                side_next  = 1'b0;
                                state_next = S_MG_LEN;
                            end
                        end
                        REQ_READ: begin
                            if ({1'b0, s_data.first_id} >= 9'(nsets_reg)) begin
                                out_next   = '{8'd0, 5'd0, 6'd0, 1'b1, ST_BADID};
                                out_v_next = 1'b1;
                            end else begin
                                state_next = S_RD_LEN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // range check, one element per cycle
            S_CHECK: begin
                if (!mg_reg && pover_reg) begin
                    out_next   = '{8'd0, 5'd0, 6'(n_reg), 1'b1, ST_RANGE};
                    state_next = S_RES;
                end else if (n_reg == '0) begin
                    out_next   = '{8'd0, 5'd0, 6'd0, 1'b1, ST_OK};
                    state_next = S_RES;
                end else if (n_reg > UNI_W'(eff_vars)) begin
                    out_next   = '{8'd0, 5'd0, 6'(n_reg), 1'b1, ST_RANGE};
                    state_next = S_RES;
                end else if ({1'b0, cur_elem} >= eff_vars) begin
                    out_next   = '{8'd0, 5'd0, 6'(n_reg), 1'b1, ST_RANGE};
                    state_next = S_RES;
                end else if (UNI_W'(pos_reg) + 1'b1 == n_reg) begin
                    sid_next   = '0;
                    state_next = S_SCAN_LEN;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            // look up the next stored set
            S_SCAN_LEN: begin
                if (sid_reg >= nsets_reg) begin
                    state_next = S_APPEND;
                    pos_next   = '0;
                    base_next  = used_reg[ADDR_W-1:0];
                    fits = (used_reg + (ADDR_W+1)'(n_reg) + 1'b1 <= (ADDR_W+1)'(STORE_WORDS))
                        && (nsets_reg < (SID_W+1)'(MAX_SETS));
                    if (!fits) begin
                        out_next   = '{8'd0, 5'd0, 6'(n_reg), 1'b1, ST_FULL};
                        state_next = S_RES;
                    end
                end else if (sid_reg == '0) begin
                    sid_next = sid_reg + 1'b1;
                end else if (sid_reg == (SID_W+1)'(1)) begin
                    if (n_reg == UNI_W'(eff_vars)) begin
                        pos_next   = '0;
                        side_next  = 1'b1;
                        state_next = S_SCAN_CMP;
                    end else begin
                        sid_next = sid_reg + 1'b1;
                    end
                end else begin
                    lm_raddr   = sid_reg[SID_W-1:0];
                    side_next  = 1'b0;
                    state_next = S_SCAN_LEN_W;
                end
            end

            S_SCAN_LEN_W: begin
                if (side_reg == 1'b0) begin
                    base_next = lm_rdata;
                    st_raddr  = lm_rdata;
                    side_next = 1'b1;
                end else begin
                    if (UNI_W'(st_rdata) == n_reg) begin
                        pos_next   = '0;
                        side_next  = 1'b0;
                        state_next = S_SCAN_CMP;
                    end else begin
                        sid_next   = sid_reg + 1'b1;
                        state_next = S_SCAN_LEN;
                    end
                end
            end

            // compare the elements, the preset full set by position
            S_SCAN_CMP: begin
                if (sid_reg == (SID_W+1)'(1)) begin
                    if ({1'b0, cur_elem} != 6'(pos_reg)) begin
                        sid_next   = sid_reg + 1'b1;
                        state_next = S_SCAN_LEN;
                    end else if (UNI_W'(pos_reg) + 1'b1 == n_reg) begin
                        out_next   = '{8'd1, 5'd0, 6'(n_reg), 1'b1, ST_OK};
                        state_next = S_RES;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end else begin
                    st_raddr   = base_reg + ADDR_W'(pos_reg) + 1'b1;
                    state_next = S_SCAN_CMP_W;
                end
            end

            S_SCAN_CMP_W: begin
                if (st_rdata != {1'b0, cur_elem}) begin
                    sid_next   = sid_reg + 1'b1;
                    state_next = S_SCAN_LEN;
                end else if (UNI_W'(pos_reg) + 1'b1 == n_reg) begin
                    out_next   = '{8'(sid_reg), 5'd0, 6'(n_reg), 1'b1, ST_OK};
                    state_next = S_RES;
                end else begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end

            // write count word then elements
            S_APPEND: begin
                st_we = 1'b1;
                if (pos_reg == '0 && !rng_reg) begin
                    st_waddr = base_reg;
                    st_wdata = 6'(n_reg);
                    rng_next = 1'b1;
                end else begin
                    st_waddr = base_reg + ADDR_W'(pos_reg) + 1'b1;
                    st_wdata = {1'b0, cur_elem};
                    if (UNI_W'(pos_reg) + 1'b1 == n_reg) begin
                        lm_we      = 1'b1;
                        nsets_next = nsets_reg + 1'b1;
                        used_next  = used_reg + (ADDR_W+1)'(n_reg) + 1'b1;
                        out_next   = '{8'(nsets_reg), 5'd0, 6'(n_reg), 1'b1, ST_OK};
                        state_next = S_RES;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end

            // hand the result over and wait for the output to drain
            S_RES: begin
                if (!out_v_reg) begin
                    out_v_next = 1'b1;
                    if (!mg_reg) begin
                        pcnt_next  = '0;
                        pover_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            // merge: fetch lengths and bases of both ids
            S_MG_LEN: begin
                lm_raddr   = side_reg ? id2_reg : id1_reg;
                state_next = S_MG_LEN_W;
                rng_next   = 1'b0;
            end

            S_MG_LEN_W: begin
                if (!rng_reg) begin
                    if (side_reg) loc2_next = lm_rdata;
                    else          loc1_next = lm_rdata;
                    st_raddr = lm_rdata;
                    rng_next = 1'b1;
                end else begin
                    if ((side_reg ? id2_reg : id1_reg) == '0) len = '0;
                    else if ((side_reg ? id2_reg : id1_reg) == SID_W'(1)) len = CNT_W'(eff_vars);
                    else if (st_rdata > 6'(MAX_VARS)) len = CNT_W'(MAX_VARS);
                    else len = CNT_W'(st_rdata);
                    if (side_reg) l2_next = len;
                    else          l1_next = len;
                    if (!side_reg) begin
                        side_next  = 1'b1;
                        state_next = S_MG_LEN;
                    end else if (id1_reg == id2_reg) begin
                        out_next   = '{8'(id1_reg), 5'd0, 6'(l1_reg), 1'b1, ST_OK};
                        if (id1_reg == '0 || id1_reg == SID_W'(1)) begin
                            out_next.set_size = 6'(l1_reg);
                        end else begin
                            out_next.set_size = st_rdata;
                        end
                        state_next = S_RES;
                    end else begin
                        i_next     = '0;
                        j_next     = '0;
                        n_next     = '0;
                        side_next  = 1'b0;
                        state_next = S_MG_ELEM;
                    end
                end
            end

            // merge: fetch a = elem(id1,i) then b = elem(id2,j)
            S_MG_ELEM: begin
                if (i_reg >= l1_reg && j_reg >= l2_reg) begin
                    pos_next   = '0;
                    rng_next   = 1'b0;
                    state_next = S_CHECK;
                end else begin
                    if (!side_reg) st_raddr = loc1_reg + ADDR_W'(i_reg) + 1'b1;
                    else           st_raddr = loc2_reg + ADDR_W'(j_reg) + 1'b1;
                    state_next = S_MG_ELEM_W;
                end
            end

            S_MG_ELEM_W: begin
                if (!side_reg) begin
                    if (i_reg >= l1_reg) a_next = 6'h3f;
                    else if (id1_reg == SID_W'(1)) a_next = 6'(i_reg);
                    else if (id1_reg == '0) a_next = '0;
                    else a_next = st_rdata;
                    side_next  = 1'b1;
                    state_next = S_MG_ELEM;
                end else begin
                    if (j_reg >= l2_reg) b = 6'h3f;
                    else if (id2_reg == SID_W'(1)) b = 6'(j_reg);
                    else if (id2_reg == '0) b = '0;
                    else b = st_rdata;
                    id1_next   = id1_reg;
                    side_next  = 1'b0;
                    state_next = S_MG_STEP;
                    a_next     = a_reg;
                    loc1_next  = loc1_reg;
                    l1_next    = l1_reg;
                    uni_we     = (n_reg < UNI_W'(MAX_VARS));
                    if (i_reg >= l1_reg || (j_reg < l2_reg && b < a_reg)) begin
                        uni_wdata = b[4:0];
                        j_next    = j_reg + 1'b1;
                    end else if (j_reg >= l2_reg || a_reg < b) begin
                        uni_wdata = a_reg[4:0];
                        i_next    = i_reg + 1'b1;
                    end else begin
                        uni_wdata = a_reg[4:0];
                        i_next    = i_reg + 1'b1;
                        j_next    = j_reg + 1'b1;
                    end
                    n_next = n_reg + 1'b1;
                end
            end

            S_MG_STEP: begin
                state_next = S_MG_ELEM;
            end

            // read: length then elements
            S_RD_LEN: begin
                lm_raddr   = id1_reg;
                rng_next   = 1'b0;
                state_next = S_RD_LEN_W;
            end

            S_RD_LEN_W: begin
                if (!rng_reg) begin
                    loc1_next = lm_rdata;
                    st_raddr  = lm_rdata;
                    rng_next  = 1'b1;
                end else begin
                    if (id1_reg == '0) len = '0;
                    else if (id1_reg == SID_W'(1)) len = CNT_W'(eff_vars);
                    else len = CNT_W'(st_rdata);
                    a_next = (id1_reg == '0 || id1_reg == SID_W'(1)) ? 6'(len) : st_rdata;
                    l1_next = (id1_reg == '0 || id1_reg == SID_W'(1)) ? len :
                              ((st_rdata > 6'(MAX_VARS)) ? CNT_W'(MAX_VARS) : CNT_W'(st_rdata));
                    i_next = '0;
                    if (((id1_reg == '0 || id1_reg == SID_W'(1)) ? 6'(len) : st_rdata) == '0) begin
                        out_next   = '{8'(id1_reg), 5'd0, 6'd0, 1'b1, ST_OK};
                        mg_next    = 1'b1;
                        state_next = S_RES;
                    end else begin
                        state_next = S_RD_ELEM;
                    end
                end
            end

            // next element read only once no beat is held or the held beat is leaving
            S_RD_ELEM: begin
                if (!out_v_reg || m_ready) begin
                    st_raddr   = loc1_reg + ADDR_W'(i_reg) + 1'b1;
                    state_next = S_RD_ELEM_W;
                end
            end

            S_RD_ELEM_W: begin
                out_next.set_id      = 8'(id1_reg);
                out_next.element_out = (id1_reg == SID_W'(1)) ? 5'(i_reg) : st_rdata[4:0];
                out_next.set_size    = a_reg;
                out_next.last_out    = (i_reg + 1'b1 == l1_reg);
                out_next.status      = ST_OK;
                state_next           = S_RD_OUT;
            end

            S_RD_OUT: begin
                if (!out_v_reg) begin
                    out_v_next = 1'b1;
                    if (i_reg + 1'b1 == l1_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RD_ELEM;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // store never grows past its size
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= (ADDR_W+1)'(STORE_WORDS))
        else $error("used words beyond store size");

    // set count only grows, by one
    a_sets_step: assert property (@(posedge aclk) disable iff (!aresetn)
        nsets_reg != $past(nsets_reg) |-> nsets_reg == $past(nsets_reg) + 1'b1)
        else $error("set count jumped");

    // no input taken while a result is held
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> !s_ready)
        else $error("input accepted with pending result");

endmodule

// File: tb/index_set_interning_table_checker.sv
// result checker for the index set interning table: predicts beats and compares them
`timescale 1ns / 1ps
module index_set_interning_table_checker
    import isit_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [5:0] cfg_data,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        error_count,
    output int        pending_results
);

    // predicted table state
    logic [5:0]  words [STORE_WORDS];
    logic [11:0] set_loc [MAX_SETS];
    int          fill_words;
    int          set_total;
    logic [4:0]  gather [MAX_VARS];
    int          gather_n;
    bit          gather_over;
    logic [5:0]  vars_cfg;

    out_beat_t   beats_due[$];

    function automatic int nvars();
        return (vars_cfg > MAX_VARS) ? MAX_VARS : int'(vars_cfg);
    endfunction

    function automatic int len_of(int id);
        if (id == 0) return 0;
        if (id == 1) return nvars();
        if (id >= MAX_SETS) return 0;
        return int'(words[set_loc[id]]);
    endfunction

    function automatic int elem_of(int id, int pos);
        int a;
        if (id == 1) return pos;
        if (id == 0 || id >= MAX_SETS) return 0;
        a = int'(set_loc[id]) + 1 + pos;
        return (a < STORE_WORDS) ? int'(words[a]) : 0;
    endfunction

    // look up or append a set; returns status, id by reference
    function automatic logic [1:0] lookup_or_add(int v[], int n, output int id);
        int nv;
        int i;
        bit same;
        nv = nvars();
        id = 0;
        if (n == 0) return ST_OK;
        if (n > nv) return ST_RANGE;
        for (i = 0; i < n; i++)
            if (v[i] >= nv) return ST_RANGE;
        for (int s = 0; s < set_total; s++) begin
            if (len_of(s) != n) continue;
            same = 1;
            for (i = 0; i < n; i++)
                if (elem_of(s, i) != v[i]) same = 0;
            if (same) begin
                id = s;
                return ST_OK;
            end
        end
        if (fill_words + n + 1 > STORE_WORDS || set_total >= MAX_SETS) return ST_FULL;
        words[fill_words] = 6'(n);
        for (i = 0; i < n; i++) words[fill_words + 1 + i] = 6'(v[i]);
        set_loc[set_total] = 12'(fill_words);
        id = set_total;
        set_total++;
        fill_words += n + 1;
        return ST_OK;
    endfunction

    function automatic out_beat_t mk(int id, int e, int sz, bit l, logic [1:0] st);
        out_beat_t b;
        b.set_id = 8'(id);
        b.element_out = 5'(e);
        b.set_size = 6'(sz);
        b.last_out = l;
        b.status = st;
        return b;
    endfunction

    // expected beats for one accepted request
    task automatic predict_request(in_beat_t r);
        int id, n, l1, l2, i, j, a, b, id1, id2;
        int v[];
        logic [1:0] st;
        id1 = int'(r.first_id);
        id2 = int'(r.second_id);
        case (r.req_type)
            REQ_INTERN: begin
                if (r.empty_set) begin
                    gather_n = 0;
                    gather_over = 0;
                    beats_due.push_back(mk(0, 0, 0, 1, ST_OK));
                end else begin
                    if (gather_n < MAX_VARS) begin
                        gather[gather_n] = r.element_index;
                        gather_n++;
                    end else gather_over = 1;
                    if (r.last_element) begin
                        n = gather_n;
                        v = new[n];
                        for (i = 0; i < n; i++) v[i] = int'(gather[i]);
                        if (gather_over) begin
                            id = 0;
                            st = ST_RANGE;
                        end else st = lookup_or_add(v, n, id);
                        beats_due.push_back(mk(id, 0, n, 1, st));
                        gather_n = 0;
                        gather_over = 0;
                    end
                end
            end
            REQ_MERGE: begin
                if (id1 >= set_total || id2 >= set_total)
                    beats_due.push_back(mk(0, 0, 0, 1, ST_BADID));
                else if (id1 == id2)
                    beats_due.push_back(mk(id1, 0, len_of(id1), 1, ST_OK));
                else begin
                    l1 = len_of(id1);
                    l2 = len_of(id2);
                    if (l1 > MAX_VARS) l1 = MAX_VARS;
                    if (l2 > MAX_VARS) l2 = MAX_VARS;
                    v = new[l1 + l2];
                    i = 0; j = 0; n = 0;
                    while (i < l1 && j < l2) begin
                        a = elem_of(id1, i);
                        b = elem_of(id2, j);
                        if (a < b) begin v[n] = a; i++; end
                        else if (a > b) begin v[n] = b; j++; end
                        else begin v[n] = a; i++; j++; end
                        n++;
                    end
                    while (i < l1) begin v[n] = elem_of(id1, i); i++; n++; end
                    while (j < l2) begin v[n] = elem_of(id2, j); j++; n++; end
                    st = lookup_or_add(v, n, id);
                    beats_due.push_back(mk(id, 0, n, 1, st));
                end
            end
            REQ_READ: begin
                if (id1 >= set_total) beats_due.push_back(mk(0, 0, 0, 1, ST_BADID));
                else begin
                    n = len_of(id1);
                    if (n == 0) beats_due.push_back(mk(id1, 0, 0, 1, ST_OK));
                    else begin
                        a = (n > 32) ? 32 : n;
                        for (i = 0; i < a; i++)
                            beats_due.push_back(mk(id1, elem_of(id1, i), n, i + 1 == a, ST_OK));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // watch the channels
    always @(posedge aclk) begin
        out_beat_t w;
        if (!aresetn) begin
            fill_words = 0;
            set_total = 2;
            gather_n = 0;
            gather_over = 0;
            vars_cfg = '0;
            beats_due.delete();
            error_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) vars_cfg = cfg_data;
            if (s_valid && s_ready) predict_request(s_data);
            if (m_valid && m_ready) begin
                if (beats_due.size() == 0) report_mismatch("unexpected beat", 1, 0);
                else begin
                    w = beats_due.pop_front();
                    if (m_data.set_id != w.set_id)
                        report_mismatch("set_id", m_data.set_id, w.set_id);
                    if (m_data.element_out != w.element_out)
                        report_mismatch("element_out", m_data.element_out, w.element_out);
                    if (m_data.set_size != w.set_size)
                        report_mismatch("set_size", m_data.set_size, w.set_size);
                    if (m_data.last_out != w.last_out)
                        report_mismatch("last_out", m_data.last_out, w.last_out);
                    if (m_data.status != w.status)
                        report_mismatch("status", m_data.status, w.status);
                end
            end
        end
        pending_results = beats_due.size();
    end

endmodule

// File: tb/index_set_interning_table_test.sv
// stimulus and verdict for the index set interning table
`timescale 1ns / 1ps
module index_set_interning_table_test;
    import isit_pkg::*;

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      cfg_valid = 0;
    logic      cfg_ready;
    logic [5:0] cfg_data = '0;
    logic      s_valid = 0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    out_beat_t m_data;
    int        error_count;
    int        pending_results;
    int        send_idle = 0;
    int        recv_stall = 0;

    index_set_interning_table dut (.*);

    index_set_interning_table_checker checker_i (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // receiver stalls
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_stall);

    // valid stays high after the beat; an idle cycle or drain lowers it, the next beat replaces its data
    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
    endtask

    task automatic write_vars(logic [5:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic in_beat_t req(logic [1:0] t, int e, bit l, bit em, int a, int b);
        in_beat_t r;
        r.req_type = t;
        r.element_index = 5'(e);
        r.last_element = l;
        r.empty_set = em;
        r.first_id = 8'(a);
        r.second_id = 8'(b);
        return r;
    endfunction

    // intern a random set, mostly sorted and in range
    task automatic send_random_set(int nv);
        int n;
        int e;
        n = $urandom_range(1, (nv > 0 && nv < 6) ? nv : 6);
        e = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) e = $urandom_range(31);
            send_beat(req(REQ_INTERN, e, i == n - 1, 0, $urandom, $urandom));
            e = e + $urandom_range(1, 4);
        end
    endtask

    task automatic random_phase(int count, int idle, int stall, int nv);
        int op;
        send_idle = idle;
        recv_stall = stall;
        for (int k = 0; k < count; k++) begin
            op = $urandom_range(99);
            if (op < 45) send_random_set(nv);
            else if (op < 70) send_beat(req(REQ_MERGE, $urandom, 1'($urandom_range(1)),
                                            1'($urandom_range(1)),
                                            $urandom_range(0, 12), $urandom_range(0, 12)));
            else if (op < 88) send_beat(req(REQ_READ, $urandom, 1'($urandom_range(1)),
                                            1'($urandom_range(1)),
                                            $urandom_range(0, 14), $urandom));
            else if (op < 93) send_beat(req(REQ_INTERN, $urandom, 0, 1, $urandom, $urandom));
            else if (op < 97) send_beat(req(2'($urandom_range(3)), $urandom,
                                            1'($urandom_range(1)), 1'($urandom_range(1)),
                                            $urandom, $urandom));
            else send_beat(req(2'd3, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                               $urandom, $urandom));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: var_count zero, then extremes
        send_beat(req(REQ_INTERN, 0, 1, 0, 0, 0));
        send_beat(req(REQ_READ, 0, 0, 0, 1, 0));
        write_vars(6'd32);
        send_beat(req(REQ_INTERN, 0, 0, 1, 0, 0));
        send_beat(req(REQ_INTERN, 31, 0, 0, 0, 0));
        send_beat(req(REQ_INTERN, 3, 1, 0, 0, 0));
        send_beat(req(REQ_INTERN, 31, 0, 0, 0, 0));
        send_beat(req(REQ_INTERN, 3, 1, 0, 0, 0));
        send_beat(req(REQ_READ, 0, 0, 0, 1, 0));
        send_beat(req(REQ_READ, 0, 0, 0, 2, 0));
        send_beat(req(REQ_READ, 0, 0, 0, 0, 0));
        send_beat(req(REQ_READ, 0, 0, 0, 255, 0));
        send_beat(req(REQ_MERGE, 0, 0, 0, 2, 1));
        send_beat(req(REQ_MERGE, 0, 0, 0, 2, 2));
        send_beat(req(REQ_MERGE, 0, 0, 0, 0, 255));
        // pending elements survive a read, then overflow past 32
        send_beat(req(REQ_INTERN, 5, 0, 0, 0, 0));
        send_beat(req(REQ_READ, 0, 0, 0, 2, 0));
        for (int i = 0; i < 33; i++) send_beat(req(REQ_INTERN, i, i == 32, 0, 0, 0));
        send_beat(req(2'd3, 31, 1, 1, 255, 255));
        drain();

        write_vars(6'd63);
        random_phase(40, 0, 0, 32);
        write_vars(6'd5);
        random_phase(50, 49, 0, 5);
        write_vars(6'd1);
        random_phase(20, 0, 49, 1);
        write_vars(6'd20);
        random_phase(50, 31, 31, 20);
        write_vars(6'd32);
        random_phase(50, 0, 0, 32);
        drain();

        if (error_count == 0 && pending_results == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
